// File: hw/rtl/hrp_pkg.sv
package hrp_pkg;

  // Length limits for the URI, a header name and a header value.
  localparam logic [11:0] MAX_URI_LEN   = 12'd2048;
  localparam logic [11:0] MAX_VALUE_LEN = 12'd1024;
  localparam logic [11:0] MAX_NAME_LEN  = 12'd128;

  // Method tokens reach their limit at this many bytes.
  localparam logic [11:0] METHOD_LIMIT  = 12'd7;
  // Version tokens longer than this are an error.
  localparam logic [11:0] VERSION_LIMIT = 12'd8;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Byte kinds.
  localparam logic [3:0] KIND_NONE    = 4'd0;
  localparam logic [3:0] KIND_METHOD  = 4'd1;
  localparam logic [3:0] KIND_URI     = 4'd2;
  localparam logic [3:0] KIND_VERSION = 4'd3;
  localparam logic [3:0] KIND_NAME    = 4'd4;
  localparam logic [3:0] KIND_HOST    = 4'd5;
  localparam logic [3:0] KIND_CTYPE   = 4'd6;
  localparam logic [3:0] KIND_AGENT   = 4'd7;
  localparam logic [3:0] KIND_VALUE   = 4'd8;

  // Method and version codes.
  localparam logic [2:0] METHOD_NONE  = 3'd0;
  localparam logic [1:0] VERSION_NONE = 2'd0;

  // Error codes.
  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_BAD_METHOD   = 4'd1;
  localparam logic [3:0] ERR_METHOD_LONG  = 4'd2;
  localparam logic [3:0] ERR_URI_LONG     = 4'd3;
  localparam logic [3:0] ERR_VERSION_LONG = 4'd4;
  localparam logic [3:0] ERR_BAD_VERSION  = 4'd5;
  localparam logic [3:0] ERR_NO_DELIM     = 4'd6;
  localparam logic [3:0] ERR_NAME_LONG    = 4'd7;
  localparam logic [3:0] ERR_VALUE_LONG   = 4'd8;

  // Keywords, left aligned in a fixed field of twelve characters.
  localparam int KW_CHARS = 12;
  localparam int KW_BITS  = 8 * KW_CHARS;

  localparam logic [KW_BITS-1:0] METHOD_KW [4] = '{
    "GET         ", "POST        ", "PUT         ", "DELETE      "};
  localparam logic [3:0] METHOD_LEN [4] = '{4'd3, 4'd4, 4'd3, 4'd6};

  localparam logic [KW_BITS-1:0] VERSION_KW [3] = '{
    "HTTP/1.0    ", "HTTP/1.1    ", "HTTP/2.0    "};
  localparam logic [3:0] VERSION_LEN [3] = '{4'd8, 4'd8, 4'd8};

  localparam logic [KW_BITS-1:0] HEADER_KW [3] = '{
    "Host        ", "Content-Type", "User-Agent  "};
  localparam logic [3:0] HEADER_LEN [3] = '{4'd4, 4'd12, 4'd10};

  // Parser phase, one-hot.
  typedef enum logic [8:0] {
    PH_METHOD  = 9'b000000001,
    PH_URI     = 9'b000000010,
    PH_VERSION = 9'b000000100,
    PH_LINEEND = 9'b000001000,
    PH_NAME    = 9'b000010000,
    PH_HOST    = 9'b000100000,
    PH_CTYPE   = 9'b001000000,
    PH_AGENT   = 9'b010000000,
    PH_VALUE   = 9'b100000000
  } phase_t;

  // Parser state carried from byte to byte.
  typedef struct packed {
    phase_t      phase;
    logic [11:0] len;
    logic [3:0]  alive;
    logic        pat;
    logic        done;
    logic [3:0]  err;
  } state_t;

  localparam state_t ST_RESET = '{
    phase: PH_METHOD, len: 12'd0, alive: 4'hF, pat: 1'b0, done: 1'b0, err: ERR_NONE};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    logic       chunk_last;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] byte_kind;
    logic       field_done;
    logic [2:0] method_code;
    logic [1:0] version_code;
    logic       request_done;
    logic [3:0] error_code;
    logic       chunk_last_out;
  } tag_t;

  // Character of a keyword at a position; positions past the field read as zero.
  function automatic logic [7:0] kw_char(input logic [KW_BITS-1:0] kw,
                                         input logic [3:0] pos);
    logic [7:0] c;
    c = 8'd0;
    for (int k = 0; k < KW_CHARS; k++) begin
      if (pos == 4'(k)) begin
        c = kw[KW_BITS-8-8*k +: 8];
      end
    end
    return c;
  endfunction

  // Byte kind of a header value phase.
  function automatic logic [3:0] value_kind(input phase_t ph);
    logic [3:0] k;
    case (ph)
      PH_HOST:  k = KIND_HOST;
      PH_CTYPE: k = KIND_CTYPE;
      PH_AGENT: k = KIND_AGENT;
      default:  k = KIND_VALUE;
    endcase
    return k;
  endfunction

endpackage

// File: hw/rtl/hrp_step.sv
module hrp_step (
  input  hrp_pkg::state_t cur,
  input  hrp_pkg::req_t   beat,
  output hrp_pkg::state_t nxt,
  output hrp_pkg::tag_t   res
);
  import hrp_pkg::*;

  state_t      s;
  logic [7:0]  b;
  logic [12:0] n;
  logic        is_crlf;
  logic [3:0]  m_alive;
  logic [3:0]  v_alive;
  logic [3:0]  h_alive;
  logic [3:0]  h0_alive;
  logic [2:0]  m_code;
  logic [1:0]  v_code;
  logic [1:0]  h_code;
  logic [3:0]  kind;
  logic        fdone;
  logic [2:0]  mcode;
  logic [1:0]  vcode;
  logic [3:0]  err;

  // Restart takes effect before this beat is handled.
  assign s       = beat.restart ? ST_RESET : cur;
  assign b       = beat.data_byte;
  assign n       = {1'b0, s.len} + 13'd1;
  assign is_crlf = (b == CH_CR) || (b == CH_LF);

  // Incremental keyword match at the current token position.
  always_comb begin
    m_alive  = s.alive;
    v_alive  = s.alive;
    h_alive  = s.alive;
    h0_alive = 4'h0;
    for (int i = 0; i < 4; i++) begin
      if (!(s.len < 12'(METHOD_LEN[i]) && kw_char(METHOD_KW[i], s.len[3:0]) == b)) begin
        m_alive[i] = 1'b0;
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (!(s.len < 12'(VERSION_LEN[i]) && kw_char(VERSION_KW[i], s.len[3:0]) == b)) begin
        v_alive[i] = 1'b0;
      end
      if (!(s.len < 12'(HEADER_LEN[i]) && kw_char(HEADER_KW[i], s.len[3:0]) == b)) begin
        h_alive[i] = 1'b0;
      end
      h0_alive[i] = (kw_char(HEADER_KW[i], 4'd0) == b);
    end
  end

  // Exact match at the end of a token; the first surviving keyword wins.
  always_comb begin
    m_code = METHOD_NONE;
    v_code = VERSION_NONE;
    h_code = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (s.alive[i] && s.len == 12'(METHOD_LEN[i])) begin
        m_code = 3'(i + 1);
      end
    end
    for (int i = 2; i >= 0; i--) begin
      if (s.alive[i] && s.len == 12'(VERSION_LEN[i])) begin
        v_code = 2'(i + 1);
      end
      if (s.alive[i] && s.len == 12'(HEADER_LEN[i])) begin
        h_code = 2'(i + 1);
      end
    end
  end

  // Phase update for one byte.
  always_comb begin
    nxt   = s;
    kind  = KIND_NONE;
    fdone = 1'b0;
    mcode = METHOD_NONE;
    vcode = VERSION_NONE;
    err   = ERR_NONE;
    if (!s.done && s.err == ERR_NONE) begin
      case (s.phase)
        PH_METHOD: begin
          if (is_crlf) begin
            // Line breaks before or inside the method are ignored.
          end else if (b == CH_SPACE) begin
            if (m_code == METHOD_NONE) begin
              err = ERR_BAD_METHOD;
            end else begin
              mcode     = m_code;
              fdone     = 1'b1;
              nxt.phase = PH_URI;
              nxt.len   = 12'd0;
            end
          end else begin
            kind      = KIND_METHOD;
            nxt.alive = m_alive;
            nxt.len   = n[11:0];
            if (n[11:0] == METHOD_LIMIT) begin
              err = ERR_METHOD_LONG;
            end
          end
        end
        PH_URI: begin
          if (b == CH_SPACE) begin
            fdone     = 1'b1;
            nxt.phase = PH_VERSION;
            nxt.len   = 12'd0;
            nxt.alive = 4'hF;
          end else begin
            kind = KIND_URI;
            if (n > {1'b0, MAX_URI_LEN}) begin
              err = ERR_URI_LONG;
            end else begin
              nxt.len = n[11:0];
            end
          end
        end
        PH_VERSION: begin
          if (b == CH_CR) begin
            if (v_code == VERSION_NONE) begin
              err = ERR_BAD_VERSION;
            end else begin
              vcode     = v_code;
              fdone     = 1'b1;
              nxt.phase = PH_LINEEND;
              nxt.len   = 12'd1;
              nxt.pat   = 1'b1;
            end
          end else begin
            kind      = KIND_VERSION;
            nxt.alive = v_alive;
            nxt.len   = n[11:0];
            if (n[11:0] > VERSION_LIMIT) begin
              err = ERR_VERSION_LONG;
            end
          end
        end
        PH_LINEEND: begin
          if (!is_crlf) begin
            // First character of a header name.
            kind      = KIND_NAME;
            nxt.alive = h0_alive;
            nxt.len   = 12'd1;
            nxt.phase = PH_NAME;
          end else if (s.len == 12'd3 && s.pat && b == CH_LF) begin
            nxt.done = 1'b1;
          end else if (s.len > 12'd3) begin
            err = ERR_NO_DELIM;
          end else begin
            if (b != (s.len[0] ? CH_LF : CH_CR)) begin
              nxt.pat = 1'b0;
            end
            nxt.len = n[11:0];
          end
        end
        PH_NAME: begin
          if (b == CH_COLON) begin
            fdone   = 1'b1;
            nxt.len = 12'd0;
            case (h_code)
              2'd1:    nxt.phase = PH_HOST;
              2'd2:    nxt.phase = PH_CTYPE;
              2'd3:    nxt.phase = PH_AGENT;
              default: nxt.phase = PH_VALUE;
            endcase
          end else begin
            kind      = KIND_NAME;
            nxt.alive = h_alive;
            if (n > {1'b0, MAX_NAME_LEN}) begin
              err = ERR_NAME_LONG;
            end else begin
              nxt.len = n[11:0];
            end
          end
        end
        PH_HOST, PH_CTYPE, PH_AGENT, PH_VALUE: begin
          if (s.len == 12'd0 && b == CH_SPACE) begin
            // Leading spaces of a value are skipped.
          end else if (b == CH_CR) begin
            fdone     = 1'b1;
            nxt.phase = PH_LINEEND;
            nxt.len   = 12'd1;
            nxt.pat   = 1'b1;
          end else begin
            kind = value_kind(s.phase);
            if (n > {1'b0, MAX_VALUE_LEN}) begin
              err = ERR_VALUE_LONG;
            end else begin
              nxt.len = n[11:0];
            end
          end
        end
        default: begin
        end
      endcase
      // The first error halts the parser and cancels the field flags.
      if (err != ERR_NONE) begin
        nxt.err = err;
        fdone   = 1'b0;
        mcode   = METHOD_NONE;
        vcode   = VERSION_NONE;
      end
    end
  end

  // Result beat.
  always_comb begin
    res.out_byte       = b;
    res.byte_kind      = kind;
    res.field_done     = fdone;
    res.method_code    = mcode;
    res.version_code   = vcode;
    res.request_done   = nxt.done;
    res.error_code     = nxt.err;
    res.chunk_last_out = beat.chunk_last;
  end

endmodule

// File: hw/rtl/http_request_header_parser_unit.sv
// Channel  Direction  Handshake             Beat
// req      in         req_valid/req_stall   hrp_pkg::req_t, one request byte
// tag      out        tag_valid/tag_stall   hrp_pkg::tag_t, the tagged byte
//
// One byte enters per cycle while req_stall is low. An accepted byte waits in the
// input register and its tag is registered in the result register as it moves on.
// The rate is set by the combinational step logic between the two registers, which
// also updates the parser state. Reset is synchronous and clears that state at once.
// A stalled tag holds the result register; the input register keeps the next
// byte and req_stall rises only when both registers are full and tag is stalled.
module http_request_header_parser_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  hrp_pkg::req_t   req,
  output logic            tag_valid,
  input  logic            tag_stall,
  output hrp_pkg::tag_t   tag
);
  import hrp_pkg::*;

  logic   in_valid;
  req_t   in_beat;
  state_t st;
  state_t st_next;
  tag_t   tag_next;
  logic   adv;

  // The held byte moves on when the result register is free or draining.
  assign adv       = in_valid && (!tag_valid || !tag_stall);
  assign req_stall = in_valid && !adv;

  hrp_step u_step (
    .cur  (st),
    .beat (in_beat),
    .nxt  (st_next),
    .res  (tag_next)
  );

  // Control registers and parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      tag_valid <= 1'b0;
      st        <= ST_RESET;
    end else begin
      if (!req_stall) begin
        in_valid <= req_valid;
      end
      if (adv) begin
        st        <= st_next;
        tag_valid <= 1'b1;
      end else if (!tag_stall) begin
        tag_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!req_stall) begin
      in_beat <= req;
    end
    if (adv) begin
      tag <= tag_next;
    end
  end

  // Completion and error never show together.
  assert property (@(posedge clk) disable iff (rst)
    tag_valid |-> !(tag.request_done && tag.error_code != ERR_NONE))
    else $error("request_done and error_code both set");

  // An error stays until a restart byte is handled.
  assert property (@(posedge clk) disable iff (rst)
    (st.err != ERR_NONE && !(adv && in_beat.restart)) |=> $stable(st.err))
    else $error("sticky error changed without restart");

  // A method or version code only comes with the byte that closes its field.
  assert property (@(posedge clk) disable iff (rst)
    (tag_valid && (tag.method_code != METHOD_NONE || tag.version_code != VERSION_NONE))
      |-> (tag.field_done && tag.byte_kind == KIND_NONE))
    else $error("code reported off a closing byte");

  // Bytes after completion carry no kind.
  assert property (@(posedge clk) disable iff (rst)
    (tag_valid && tag.request_done) |-> tag.byte_kind == KIND_NONE)
    else $error("byte tagged after request completion");

  // The input side stalls only while a byte is held.
  assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (in_valid && tag_valid && tag_stall))
    else $error("input stalled without a full pipeline");

endmodule

// File: dv/hrp_tag_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the request-head tagger, predicts the tag of every
// accepted request byte and compares each tag beat against the oldest one.
module hrp_tag_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  hrp_pkg::req_t req,
  input  logic          tag_valid,
  input  logic          tag_stall,
  input  hrp_pkg::tag_t tag,
  output int            fails,
  output int            pending
);
  import hrp_pkg::*;

  typedef enum logic [1:0] {
    PARSING,
    FINISHED,
    FAULTED
  } halt_t;

  // Keyword groups laid out in one table: methods, versions, header names.
  localparam int MTH_BASE = 0;
  localparam int MTH_NUM  = 4;
  localparam int VER_BASE = 4;
  localparam int VER_NUM  = 3;
  localparam int HDR_BASE = 7;
  localparam int HDR_NUM  = 3;

  string keywords [10] = '{"GET", "POST", "PUT", "DELETE",
                           "HTTP/1.0", "HTTP/1.1", "HTTP/2.0",
                           "Host", "Content-Type", "User-Agent"};

  // Value phase chosen by the header name match; no match means a plain value.
  phase_t value_phase [4] = '{PH_VALUE, PH_HOST, PH_CTYPE, PH_AGENT};

  // Parser state as the tagger should hold it.
  phase_t      ph;
  logic [11:0] tok_len;
  logic [3:0]  alive;
  logic        crlf_run;
  halt_t       halt;
  logic [3:0]  err_held;

  tag_t pending_tags [$];
  int   fail_count = 0;

  task automatic clear_parser();
    ph       = PH_METHOD;
    tok_len  = '0;
    alive    = 4'hF;
    crlf_run = 1'b0;
    halt     = PARSING;
    err_held = ERR_NONE;
  endtask

  // Drop the keywords of a group whose character at pos differs from c.
  function automatic logic [3:0] narrow(input logic [3:0] live, input int base,
                                        input int num, input int pos,
                                        input logic [7:0] c);
    logic [3:0] res;
    string w;
    res = live;
    for (int i = 0; i < num; i++) begin
      w = keywords[base + i];
      if (pos >= w.len() || w[pos] != c) begin
        res[i] = 1'b0;
      end
    end
    return res;
  endfunction

  // One-based index of the live keyword whose length equals the token's, or 0.
  function automatic int exact_word(input logic [3:0] live, input int base,
                                    input int num, input int length);
    string w;
    for (int i = 0; i < num; i++) begin
      w = keywords[base + i];
      if (live[i] && w.len() == length) begin
        return i + 1;
      end
    end
    return 0;
  endfunction

  task automatic open_line_end();
    ph       = PH_LINEEND;
    tok_len  = 12'd1;
    crlf_run = 1'b1;
  endtask

  // Advance the parser by one request byte and form the tag it should get.
  task automatic tag_byte(input req_t r, output tag_t t);
    logic [7:0] c;
    logic [3:0] kind;
    logic [3:0] err;
    logic       fdone;
    logic [2:0] mcode;
    logic [1:0] vcode;
    int         hit;
    int         n;
    c     = r.data_byte;
    kind  = KIND_NONE;
    err   = ERR_NONE;
    fdone = 1'b0;
    mcode = METHOD_NONE;
    vcode = VERSION_NONE;
    if (r.restart) begin
      clear_parser();
    end
    if (halt == PARSING) begin
      case (ph)
        PH_METHOD: begin
          // CR and LF are skipped anywhere in the method.
          if (c == CH_SPACE) begin
            hit = exact_word(alive, MTH_BASE, MTH_NUM, tok_len);
            if (hit == 0) begin
              err = ERR_BAD_METHOD;
            end else begin
              mcode   = 3'(hit);
              fdone   = 1'b1;
              ph      = PH_URI;
              tok_len = '0;
            end
          end else if (c != CH_CR && c != CH_LF) begin
            kind    = KIND_METHOD;
            alive   = narrow(alive, MTH_BASE, MTH_NUM, tok_len, c);
            tok_len = tok_len + 1'b1;
            if (tok_len == METHOD_LIMIT) begin
              err = ERR_METHOD_LONG;
            end
          end
        end
        PH_URI: begin
          if (c == CH_SPACE) begin
            fdone   = 1'b1;
            ph      = PH_VERSION;
            tok_len = '0;
            alive   = 4'hF;
          end else begin
            kind = KIND_URI;
            n    = tok_len + 1;
            if (n > MAX_URI_LEN) begin
              err = ERR_URI_LONG;
            end else begin
              tok_len = 12'(n);
            end
          end
        end
        PH_VERSION: begin
          if (c == CH_CR) begin
            hit = exact_word(alive, VER_BASE, VER_NUM, tok_len);
            if (hit == 0) begin
              err = ERR_BAD_VERSION;
            end else begin
              vcode = 2'(hit);
              fdone = 1'b1;
              open_line_end();
            end
          end else begin
            kind    = KIND_VERSION;
            alive   = narrow(alive, VER_BASE, VER_NUM, tok_len, c);
            tok_len = tok_len + 1'b1;
            if (tok_len > VERSION_LIMIT) begin
              err = ERR_VERSION_LONG;
            end
          end
        end
        PH_LINEEND: begin
          // Any other byte opens a header name; CR LF CR LF closes the head.
          if (c != CH_CR && c != CH_LF) begin
            kind    = KIND_NAME;
            alive   = narrow(4'h7, HDR_BASE, HDR_NUM, 0, c);
            tok_len = 12'd1;
            ph      = PH_NAME;
          end else if (tok_len == 12'd3 && crlf_run && c == CH_LF) begin
            halt = FINISHED;
          end else if (tok_len > 12'd3) begin
            err = ERR_NO_DELIM;
          end else begin
            if (c != (tok_len[0] ? CH_LF : CH_CR)) begin
              crlf_run = 1'b0;
            end
            tok_len = tok_len + 1'b1;
          end
        end
        PH_NAME: begin
          if (c == CH_COLON) begin
            hit     = exact_word(alive, HDR_BASE, HDR_NUM, tok_len);
            fdone   = 1'b1;
            ph      = value_phase[hit];
            tok_len = '0;
          end else begin
            kind  = KIND_NAME;
            alive = narrow(alive, HDR_BASE, HDR_NUM, tok_len, c);
            n     = tok_len + 1;
            if (n > MAX_NAME_LEN) begin
              err = ERR_NAME_LONG;
            end else begin
              tok_len = 12'(n);
            end
          end
        end
        PH_HOST, PH_CTYPE, PH_AGENT, PH_VALUE: begin
          // Leading spaces of a value are skipped and tagged with no kind.
          if (c == CH_CR) begin
            fdone = 1'b1;
            open_line_end();
          end else if (!(tok_len == 0 && c == CH_SPACE)) begin
            case (ph)
              PH_HOST:  kind = KIND_HOST;
              PH_CTYPE: kind = KIND_CTYPE;
              PH_AGENT: kind = KIND_AGENT;
              default:  kind = KIND_VALUE;
            endcase
            n = tok_len + 1;
            if (n > MAX_VALUE_LEN) begin
              err = ERR_VALUE_LONG;
            end else begin
              tok_len = 12'(n);
            end
          end
        end
        default: begin
        end
      endcase
      if (err != ERR_NONE) begin
        halt     = FAULTED;
        err_held = err;
        fdone    = 1'b0;
        mcode    = METHOD_NONE;
        vcode    = VERSION_NONE;
      end
    end
    t.out_byte       = c;
    t.byte_kind      = kind;
    t.field_done     = fdone;
    t.method_code    = mcode;
    t.version_code   = vcode;
    t.request_done   = (halt == FINISHED);
    t.error_code     = (halt == FAULTED) ? err_held : ERR_NONE;
    t.chunk_last_out = r.chunk_last;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Compare tag beats first, then predict the request byte of the same edge.
  always @(posedge clk) begin : track
    tag_t want;
    if (rst) begin
      clear_parser();
      pending_tags.delete();
    end else begin
      if (tag_valid && !tag_stall) begin
        if (pending_tags.size() == 0) begin
          $error("tag beat for byte 0x%02h with no request byte outstanding",
                 tag.out_byte);
          fail_count++;
        end else begin
          want = pending_tags.pop_front();
          check_field("out_byte", want.out_byte, tag.out_byte);
          check_field("byte_kind", want.byte_kind, tag.byte_kind);
          check_field("field_done", want.field_done, tag.field_done);
          check_field("method_code", want.method_code, tag.method_code);
          check_field("version_code", want.version_code, tag.version_code);
          check_field("request_done", want.request_done, tag.request_done);
          check_field("error_code", want.error_code, tag.error_code);
          check_field("chunk_last_out", want.chunk_last_out, tag.chunk_last_out);
        end
      end
      if (req_valid && !req_stall) begin
        tag_byte(req, want);
        pending_tags.push_back(want);
      end
    end
    fails   <= fail_count;
    pending <= pending_tags.size();
  end

endmodule

// File: dv/tb_http_request_header_parser_unit.sv
`timescale 1ns / 1ps

module tb_http_request_header_parser_unit;
  import hrp_pkg::*;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic tag_valid;
  logic tag_stall = 1'b0;
  tag_t tag;

  int fails;
  int pending;

  logic idle_on = 1'b1;
  int   stall_left = 0;
  int   bytes_sent = 0;
  int   bursts_sent = 0;

  logic [7:0] burst_q [$];

  string method_names  [4] = '{"GET", "POST", "PUT", "DELETE"};
  string version_names [3] = '{"HTTP/1.0", "HTTP/1.1", "HTTP/2.0"};
  string header_names  [3] = '{"Host", "Content-Type", "User-Agent"};

  always #5 clk = ~clk;

  http_request_header_parser_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .tag_valid (tag_valid),
    .tag_stall (tag_stall),
    .tag       (tag)
  );

  hrp_tag_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .tag_valid (tag_valid),
    .tag_stall (tag_stall),
    .tag       (tag),
    .fails     (fails),
    .pending   (pending)
  );

  // Receiver back-pressure in random bursts.
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      stall_left <= 0;
      tag_stall  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      tag_stall  <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 13);
      tag_stall  <= 1'b1;
    end else begin
      tag_stall <= 1'b0;
    end
  end

  // Present one request byte and hold it until the beat is taken.
  task automatic send_beat(input logic [7:0] c, input logic rs);
    req_t beat;
    beat.data_byte  = c;
    beat.restart    = rs;
    beat.chunk_last = ($urandom_range(0, 7) == 0);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= beat;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Send the built byte sequence; restart may ride on the first byte and on one
  // byte in the middle.
  task automatic send_burst(input bit restart_first, input int mid);
    for (int i = 0; i < burst_q.size(); i++) begin
      send_beat(burst_q[i], (i == 0 && restart_first) || i == mid);
    end
    bursts_sent++;
  endtask

  // Stop sending until every outstanding tag has come back.
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      burst_q.push_back(s[i]);
    end
  endtask

  task automatic put_crlf();
    burst_q.push_back(CH_CR);
    burst_q.push_back(CH_LF);
  endtask

  task automatic put_rand(input int count, input logic [7:0] ban_a,
                          input logic [7:0] ban_b);
    logic [7:0] c;
    repeat (count) begin
      do c = 8'($urandom_range(0, 255)); while (c == ban_a || c == ban_b);
      burst_q.push_back(c);
    end
  endtask

  task automatic send_text(input string s, input bit restart_first);
    burst_q.delete();
    put_text(s);
    send_burst(restart_first, -1);
  endtask

  // Hand-built requests: every field kind, empty fields, byte extremes and the
  // method, version and line-end errors the parser can raise.
  task automatic directed_cases();
    burst_q.delete();
    put_text("GET /index.html HTTP/1.1");
    put_crlf();
    put_text("Host: example");
    put_crlf();
    put_text("Content-Type:");
    put_crlf();
    put_text("User-Agent:   probe/1");
    put_crlf();
    put_text("X-Other:v");
    put_crlf();
    put_crlf();
    burst_q.push_back(8'hFF);
    burst_q.push_back(8'h00);
    send_burst(1'b1, -1);

    burst_q.delete();
    put_text("DELETE /");
    burst_q.push_back(8'h00);
    burst_q.push_back(8'hFF);
    put_text(" HTTP/2.0");
    put_crlf();
    put_crlf();
    send_burst(1'b1, -1);

    // Empty URI, then CR and LF inside the method token.
    burst_q.delete();
    put_text("POST  HTTP/1.0");
    put_crlf();
    put_crlf();
    send_burst(1'b1, -1);
    burst_q.delete();
    burst_q.push_back(CH_LF);
    put_text("G");
    burst_q.push_back(CH_CR);
    put_text("E");
    burst_q.push_back(CH_LF);
    put_text("T / HTTP/1.1");
    put_crlf();
    put_crlf();
    send_burst(1'b1, -1);

    send_text(" GET", 1'b1);
    send_text("OPTIONS /", 1'b1);
    send_text("GETS / ", 1'b1);
    send_text("PUT / HTTP/1.10", 1'b1);

    burst_q.delete();
    put_text("PUT / HTTP/1.2");
    burst_q.push_back(CH_CR);
    send_burst(1'b1, -1);
    burst_q.delete();
    put_text("GET / ");
    burst_q.push_back(CH_CR);
    send_burst(1'b1, -1);

    // A broken line end keeps counting until the run is too long.
    burst_q.delete();
    put_text("GET / HTTP/1.1");
    burst_q.push_back(CH_CR);
    put_crlf();
    put_crlf();
    send_burst(1'b1, -1);

    // Bytes after an error are ignored until a restart cuts a request short.
    send_text("xyz", 1'b0);
    send_text("GET /a", 1'b1);
    burst_q.delete();
    put_text("PUT / HTTP/1.0");
    put_crlf();
    put_crlf();
    send_burst(1'b1, -1);
  endtask

  // Each length limit met exactly, then each one exceeded by a single byte.
  task automatic limit_cases();
    burst_q.delete();
    put_text("GET ");
    put_rand(MAX_URI_LEN, CH_SPACE, CH_SPACE);
    put_text(" HTTP/1.1");
    put_crlf();
    put_rand(1, CH_CR, CH_LF);
    put_rand(MAX_NAME_LEN - 1, CH_COLON, CH_COLON);
    burst_q.push_back(CH_COLON);
    put_rand(MAX_VALUE_LEN, CH_CR, CH_SPACE);
    put_crlf();
    put_text("Host:");
    put_rand(MAX_VALUE_LEN + 1, CH_CR, CH_SPACE);
    send_burst(1'b1, -1);

    burst_q.delete();
    put_text("PUT ");
    put_rand(MAX_URI_LEN + 1, CH_SPACE, CH_SPACE);
    send_burst(1'b1, -1);

    burst_q.delete();
    put_text("POST / HTTP/1.0");
    put_crlf();
    put_rand(1, CH_CR, CH_LF);
    put_rand(MAX_NAME_LEN, CH_COLON, CH_COLON);
    send_burst(1'b1, -1);
  endtask

  // Mostly well-formed requests with random content; some noise, near-miss
  // keywords, corrupted bytes and truncated sequences.
  task automatic build_request();
    int pick;
    int n_hdr;
    int keep;
    burst_q.delete();
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 20)) burst_q.push_back(8'($urandom_range(0, 255)));
      return;
    end

    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      put_rand($urandom_range(0, 8), CH_SPACE, CH_SPACE);
    end else begin
      if (pick == 1) begin
        burst_q.push_back(CH_LF);
      end
      put_text(method_names[$urandom_range(0, 3)]);
      if (pick == 2) begin
        put_text("S");
      end
    end
    burst_q.push_back(CH_SPACE);

    put_rand(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12), CH_SPACE, CH_SPACE);
    burst_q.push_back(CH_SPACE);

    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      put_rand($urandom_range(0, 10), CH_CR, CH_CR);
    end else if (pick == 1) begin
      put_text("HTTP/3.0");
    end else begin
      put_text(version_names[$urandom_range(0, 2)]);
      if (pick == 2) begin
        put_text("0");
      end
    end
    put_crlf();

    n_hdr = $urandom_range(0, 4);
    repeat (n_hdr) begin
      pick = $urandom_range(0, 10);
      if (pick < 6) begin
        put_text(header_names[$urandom_range(0, 2)]);
      end else if (pick == 6) begin
        put_text("Hos");
      end else if (pick == 7) begin
        put_text("Content-Typed");
      end else if (pick == 8) begin
        put_text("host");
      end else begin
        put_rand(1, CH_CR, CH_LF);
        put_rand($urandom_range(0, 10), CH_COLON, CH_COLON);
      end
      burst_q.push_back(CH_COLON);
      repeat ($urandom_range(0, 2)) burst_q.push_back(CH_SPACE);
      put_rand($urandom_range(0, 16), CH_CR, CH_CR);
      put_crlf();
    end

    // Closing empty line, sometimes malformed.
    pick = $urandom_range(0, 14);
    if (pick == 0) begin
      burst_q.push_back(CH_LF);
    end else if (pick == 1) begin
      burst_q.push_back(CH_CR);
      burst_q.push_back(CH_CR);
    end else begin
      put_crlf();
    end
    repeat ($urandom_range(0, 2)) burst_q.push_back(8'($urandom_range(0, 255)));

    if ($urandom_range(0, 19) == 0) begin
      burst_q[$urandom_range(0, burst_q.size() - 1)] = 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 29) == 0) begin
      keep = $urandom_range(1, burst_q.size());
      while (burst_q.size() > keep) void'(burst_q.pop_back());
    end
  endtask

  initial begin
    int start;
    int mid;
    bit paused;
    paused = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_cases();
    drain();
    limit_cases();
    drain();

    start = bytes_sent;
    while (bytes_sent - start < 1000) begin
      if (bytes_sent - start >= 850) begin
        idle_on <= 1'b0;
      end
      if (!paused && bytes_sent - start >= 400) begin
        drain();
        paused = 1'b1;
      end
      build_request();
      mid = -1;
      if (burst_q.size() > 1 && $urandom_range(0, 39) == 0) begin
        mid = $urandom_range(1, burst_q.size() - 1);
      end
      send_burst($urandom_range(0, 19) != 0, mid);
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d request bytes in %0d sequences: directed field and error cases,",
             bytes_sent, bursts_sent);
    $display("all three length limits, and %0d bytes of random requests.",
             bytes_sent - start);
    if (fails == 0) begin
      $display("tb_http_request_header_parser_unit passed");
    end else begin
      $display("tb_http_request_header_parser_unit failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #20ms;
    $display("tb_http_request_header_parser_unit failed");
    $finish;
  end

endmodule
